>>> rtl/core/ars_pkg.sv
`default_nettype none

package ars_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int CW   = COORD_WIDTH;
    // magnitude of a coordinate difference, also the root width
    localparam int MW   = COORD_WIDTH + 1;
    // configuration register width
    localparam int RGW  = COORD_WIDTH - 1;
    // quotient bits of every divider
    localparam int QW   = RGW;
    // sum of squares and its trial word
    localparam int SQW  = 2 * MW;
    localparam int SQX  = SQW + 1;
    // speed and target velocity products
    localparam int PSW  = RGW + MW;
    localparam int TVW  = MW + RGW;
    // acceleration divider remainder
    localparam int AW   = RGW + QW;

    // pipeline stage numbers
    localparam int S_IN  = 0;
    localparam int S_SQ  = 1;
    localparam int S_SUM = 2;
    localparam int S_SPM = S_SUM + MW + 1;
    localparam int S_TVM = S_SPM + QW + 1;
    localparam int S_ERR = S_TVM + QW + 1;
    localparam int S_OUT = S_ERR + QW + 1;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_RADIUS  = 2'd0,
        CFG_SLOW_RADIUS    = 2'd1,
        CFG_TIME_TO_TARGET = 2'd2,
        CFG_MAX_SPEED      = 2'd3
    } t_cfg_idx;

    localparam logic [RGW-1:0] TARGET_RADIUS_RST  = RGW'(32768);
    localparam logic [RGW-1:0] SLOW_RADIUS_RST    = RGW'(327680);
    localparam logic [RGW-1:0] TIME_TO_TARGET_RST = RGW'(6554);
    localparam logic [RGW-1:0] MAX_SPEED_RST      = RGW'(281805);

    localparam logic [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic [2:0][MW-1:0] dmag;
        logic [2:0]         dneg;
        logic [2:0][CW-1:0] vel;
        logic [MW-1:0]      dlen;
        logic               near;
        logic               far;
        logic               szero;
        logic               dzero;
        logic [2:0]         eneg;
        logic [2:0]         ezero;
        logic [2:0]         ovf;
    } t_ctx;

endpackage

`default_nettype wire

>>> rtl/core/ars_if.sv
`default_nettype none

interface ars_in_if;
    logic                            valid;
    logic                            ready;
    logic [ars_pkg::COORD_WIDTH-1:0] pos_x;
    logic [ars_pkg::COORD_WIDTH-1:0] pos_y;
    logic [ars_pkg::COORD_WIDTH-1:0] pos_z;
    logic [ars_pkg::COORD_WIDTH-1:0] vel_x;
    logic [ars_pkg::COORD_WIDTH-1:0] vel_y;
    logic [ars_pkg::COORD_WIDTH-1:0] vel_z;
    logic [ars_pkg::COORD_WIDTH-1:0] goal_x;
    logic [ars_pkg::COORD_WIDTH-1:0] goal_y;
    logic [ars_pkg::COORD_WIDTH-1:0] goal_z;

    modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    goal_x, goal_y, goal_z, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  goal_x, goal_y, goal_z, output ready);
endinterface

interface ars_out_if;
    logic                            valid;
    logic                            ready;
    logic [ars_pkg::COORD_WIDTH-1:0] accel_x;
    logic [ars_pkg::COORD_WIDTH-1:0] accel_y;
    logic [ars_pkg::COORD_WIDTH-1:0] accel_z;

    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

`default_nettype wire

>>> rtl/core/arrive_steering_core.sv
// channel   dir  handshake        payload
// i_item    in   valid / ready    pos_xyz, vel_xyz, goal_xyz (signed Q16.16)
// o_result  out  valid / ready    accel_xyz (signed Q16.16, saturated)
// i_cfg     in   i_cfg_we         i_cfg_idx, i_cfg_data (31 bit registers)
//
// one beat accepted per cycle except while a stall holds the pipeline
// the pipeline holds a 33-step square root and three 31-step dividers
// i_rst_n is synchronous: it clears all stage valids and loads register defaults
// on a stall the whole pipeline holds; ready falls only while a result waits
`default_nettype none

module arrive_steering_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [ars_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [ars_pkg::RGW-1:0]          i_cfg_data,
    ars_in_if.sink                                i_item,
    ars_out_if.source                             o_result
);

    localparam int CW    = ars_pkg::CW;
    localparam int MW    = ars_pkg::MW;
    localparam int RGW   = ars_pkg::RGW;
    localparam int QW    = ars_pkg::QW;
    localparam int SQW   = ars_pkg::SQW;
    localparam int SQX   = ars_pkg::SQX;
    localparam int PSW   = ars_pkg::PSW;
    localparam int TVW   = ars_pkg::TVW;
    localparam int AW    = ars_pkg::AW;
    localparam int S_SPM = ars_pkg::S_SPM;
    localparam int S_TVM = ars_pkg::S_TVM;
    localparam int S_ERR = ars_pkg::S_ERR;
    localparam int S_OUT = ars_pkg::S_OUT;

    // configuration registers
    logic [RGW-1:0] r_target;
    logic [RGW-1:0] r_slow;
    logic [RGW-1:0] r_ttt;
    logic [RGW-1:0] r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= ars_pkg::TARGET_RADIUS_RST;
            r_slow   <= ars_pkg::SLOW_RADIUS_RST;
            r_ttt    <= ars_pkg::TIME_TO_TARGET_RST;
            r_max    <= ars_pkg::MAX_SPEED_RST;
        end else if (i_cfg_we) begin
            unique case (ars_pkg::t_cfg_idx'(i_cfg_idx))
                ars_pkg::CFG_TARGET_RADIUS:  r_target <= i_cfg_data;
                ars_pkg::CFG_SLOW_RADIUS:    r_slow   <= i_cfg_data;
                ars_pkg::CFG_TIME_TO_TARGET: r_ttt    <= i_cfg_data;
                ars_pkg::CFG_MAX_SPEED:      r_max    <= i_cfg_data;
            endcase
        end
    end

    // global advance
    logic adv;
    logic r_vld [0:S_OUT];

    assign adv          = !r_vld[S_OUT] || o_result.ready;
    assign i_item.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= S_OUT; s++) r_vld[s] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_item.valid;
            for (int s = 1; s <= S_OUT; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // input stage: differences and magnitudes
    logic [2:0][CW-1:0] pos;
    logic [2:0][CW-1:0] goal;
    logic [2:0][CW-1:0] vin;
    logic [2:0][MW-1:0] diff;
    ars_pkg::t_ctx      n_ctx0;
    ars_pkg::t_ctx      r_ctx [0:S_OUT-1];
    ars_pkg::t_ctx      n_ctx [1:S_OUT-1];

    assign pos  = {i_item.pos_z, i_item.pos_y, i_item.pos_x};
    assign goal = {i_item.goal_z, i_item.goal_y, i_item.goal_x};
    assign vin  = {i_item.vel_z, i_item.vel_y, i_item.vel_x};

    always_comb begin
        n_ctx0 = '0;
        for (int i = 0; i < 3; i++) begin
            diff[i] = {goal[i][CW-1], goal[i]} - {pos[i][CW-1], pos[i]};
            n_ctx0.dneg[i] = diff[i][MW-1];
            n_ctx0.dmag[i] = diff[i][MW-1] ? (MW'(0) - diff[i]) : diff[i];
            n_ctx0.vel[i]  = vin[i];
        end
    end

    // squares and their sum
    logic [SQW-1:0] r_sq [3];
    logic [SQW-1:0] r_srem  [0:MW];
    logic [MW-1:0]  r_sroot [0:MW];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= SQW'(r_ctx[0].dmag[i]) * SQW'(r_ctx[0].dmag[i]);
            end
            r_srem[0]  <= r_sq[0] + r_sq[1] + r_sq[2];
            r_sroot[0] <= '0;
        end
    end

    // square root, one result bit per stage
    for (genvar j = 1; j <= MW; j++) begin : g_sqrt
        localparam int B = MW - j;
        logic [SQX-1:0] trial;
        logic [SQX-1:0] remx;
        assign trial = (SQX'(r_sroot[j-1]) << (B + 1)) | (SQX'(1) << (2 * B));
        assign remx  = SQX'(r_srem[j-1]);
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (remx >= trial) begin
                    r_srem[j]  <= SQW'(remx - trial);
                    r_sroot[j] <= r_sroot[j-1] | (MW'(1) << B);
                end else begin
                    r_srem[j]  <= r_srem[j-1];
                    r_sroot[j] <= r_sroot[j-1];
                end
            end
        end
    end

    // speed = max_speed * dist / slow_radius; the dividend is zero when far or slow_radius is zero
    logic [PSW-1:0] r_prem [0:QW];
    logic [QW-1:0]  r_pq   [0:QW];
    logic           sp_far;
    logic           sp_szero;

    assign sp_far   = r_sroot[MW] > MW'(r_slow);
    assign sp_szero = r_slow == '0;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prem[0] <= (sp_far || sp_szero) ? '0 : PSW'(r_max) * PSW'(r_sroot[MW]);
            r_pq[0]   <= '0;
        end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_spdiv
        localparam int B = QW - j;
        logic [PSW-1:0] cmp;
        assign cmp = PSW'(r_slow) << B;
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (r_prem[j-1] >= cmp) begin
                    r_prem[j] <= r_prem[j-1] - cmp;
                    r_pq[j]   <= r_pq[j-1] | (QW'(1) << B);
                end else begin
                    r_prem[j] <= r_prem[j-1];
                    r_pq[j]   <= r_pq[j-1];
                end
            end
        end
    end

    // target velocity magnitude = |d| * speed / dist
    logic [RGW-1:0] tv_speed;
    logic [TVW-1:0] r_trem [3][0:QW];
    logic [QW-1:0]  r_tq   [3][0:QW];

    always_comb begin
        if (r_ctx[S_TVM-1].far) begin
            tv_speed = r_max;
        end else if (r_ctx[S_TVM-1].szero) begin
            tv_speed = '0;
        end else begin
            tv_speed = r_pq[QW];
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_tv_lane
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_trem[l][0] <= TVW'(r_ctx[S_TVM-1].dmag[l]) * TVW'(tv_speed);
                r_tq[l][0]   <= '0;
            end
        end
        for (genvar j = 1; j <= QW; j++) begin : g_tvdiv
            localparam int B = QW - j;
            logic [TVW-1:0] cmp;
            assign cmp = TVW'(r_ctx[S_TVM+j-1].dlen) << B;
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    if (r_trem[l][j-1] >= cmp) begin
                        r_trem[l][j] <= r_trem[l][j-1] - cmp;
                        r_tq[l][j]   <= r_tq[l][j-1] | (QW'(1) << B);
                    end else begin
                        r_trem[l][j] <= r_trem[l][j-1];
                        r_tq[l][j]   <= r_tq[l][j-1];
                    end
                end
            end
        end
    end

    // velocity error and its side flags
    logic [2:0][MW-1:0] e_tv;
    logic [2:0][MW-1:0] e_err;
    logic [2:0][MW-1:0] e_mag;

    always_comb begin
        for (int s = 1; s < S_OUT; s++) n_ctx[s] = r_ctx[s-1];
        n_ctx[S_SPM].dlen  = r_sroot[MW];
        n_ctx[S_SPM].near  = r_sroot[MW] < MW'(r_target);
        n_ctx[S_SPM].far   = sp_far;
        n_ctx[S_SPM].szero = sp_szero;
        n_ctx[S_SPM].dzero = r_sroot[MW] == '0;
        for (int i = 0; i < 3; i++) begin
            if (r_ctx[S_ERR-1].dzero) begin
                e_tv[i] = '0;
            end else if (r_ctx[S_ERR-1].dneg[i]) begin
                e_tv[i] = MW'(0) - MW'(r_tq[i][QW]);
            end else begin
                e_tv[i] = MW'(r_tq[i][QW]);
            end
            e_err[i] = e_tv[i] - {r_ctx[S_ERR-1].vel[i][CW-1], r_ctx[S_ERR-1].vel[i]};
            e_mag[i] = e_err[i][MW-1] ? (MW'(0) - e_err[i]) : e_err[i];
            n_ctx[S_ERR].eneg[i]  = e_err[i][MW-1];
            n_ctx[S_ERR].ezero[i] = e_err[i] == '0;
            // quotient would not fit in the result
            n_ctx[S_ERR].ovf[i]   = AW'(e_mag[i]) >=
                                    (AW'(r_ttt) << (QW - ars_pkg::FRAC_BITS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ctx[0] <= n_ctx0;
            for (int s = 1; s < S_OUT; s++) r_ctx[s] <= n_ctx[s];
        end
    end

    // acceleration = (|err| << frac) / time_to_target
    logic [AW-1:0] r_arem [3][0:QW];
    logic [QW-1:0] r_aq   [3][0:QW];

    for (genvar l = 0; l < 3; l++) begin : g_ac_lane
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_arem[l][0] <= AW'(e_mag[l]) << ars_pkg::FRAC_BITS;
                r_aq[l][0]   <= '0;
            end
        end
        for (genvar j = 1; j <= QW; j++) begin : g_acdiv
            localparam int B = QW - j;
            logic [AW-1:0] cmp;
            assign cmp = AW'(r_ttt) << B;
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    if (r_arem[l][j-1] >= cmp) begin
                        r_arem[l][j] <= r_arem[l][j-1] - cmp;
                        r_aq[l][j]   <= r_aq[l][j-1] | (QW'(1) << B);
                    end else begin
                        r_arem[l][j] <= r_arem[l][j-1];
                        r_aq[l][j]   <= r_aq[l][j-1];
                    end
                end
            end
        end
    end

    // output register
    ars_pkg::t_ctx      oc;
    logic [2:0][CW-1:0] n_accel;
    logic [2:0][CW-1:0] r_accel;

    assign oc = r_ctx[S_OUT-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (oc.near) begin
                n_accel[i] = (oc.vel[i] == ars_pkg::SMIN) ? ars_pkg::SMAX
                                                          : CW'(0) - oc.vel[i];
            end else if (oc.ezero[i]) begin
                n_accel[i] = '0;
            end else if (oc.ovf[i]) begin
                n_accel[i] = oc.eneg[i] ? ars_pkg::SMIN : ars_pkg::SMAX;
            end else if (oc.eneg[i]) begin
                n_accel[i] = CW'(0) - CW'(r_aq[i][QW]);
            end else begin
                n_accel[i] = CW'(r_aq[i][QW]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_accel <= n_accel;
        end
    end

    assign o_result.valid   = r_vld[S_OUT];
    assign o_result.accel_x = r_accel[0];
    assign o_result.accel_y = r_accel[1];
    assign o_result.accel_z = r_accel[2];

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid right after reset");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> r_vld[0])
        else $error("accepted beat did not enter the pipeline");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> (o_result.valid && $stable(r_accel)))
        else $error("waiting result changed during stall");

    a_near_negates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[S_OUT-1] && adv && oc.near && oc.vel[0] != ars_pkg::SMIN)
        |=> (r_accel[0] == CW'(0) - $past(oc.vel[0])))
        else $error("arrival result is not the negated velocity");

endmodule

`default_nettype wire
